FILE: sv/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the planar rigid transform
// Fixed-point formats, register indexes, the arctangent table of the
// rotation unit and the status bundle that it hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 2'd2;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned COORD_W    = 32;

	// Rotation unit defaults and limits.
	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned ATAN_LEN         = 24;
	localparam int unsigned ATAN_IDX_W       = 5;

	// Q2.30 working formats of the rotation unit.
	localparam int unsigned CORDIC_XW = 34;
	localparam int unsigned CORDIC_ZW = 35;
	localparam logic signed [CORDIC_ZW-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [CORDIC_ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [CORDIC_XW-1:0] Q30_GAIN_INV = 34'sd652032874;

	// Cosine and sine are Q1.16 held in 18 bits.
	localparam int unsigned TRIG_W = 18;
	localparam logic signed [TRIG_W-1:0] UNIT_Q16 = 18'sd65536;

	// Status of the rotation unit as seen by the datapath.
	typedef struct packed {
		logic                     busy;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} prt_trig_t;

	// atan(2^-i) in Q2.30, truncated.
	function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/prt_cordic.sv
// ----------------------------------------------------------------------------
// prt_cordic: iterative cosine and sine of the rotation angle
// On an angle write it reduces the angle to +-pi/2, runs one shift-and-add
// rotation step per cycle and then rounds the result to Q1.16 and keeps it.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_cordic
	import prt_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [ANGLE_W-1:0]   angle,
	output prt_trig_t                 trig
);

	localparam int unsigned STEPS_RUN = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int unsigned STEP_W    = (STEPS_RUN > 1) ? $clog2(STEPS_RUN) : 1;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_RUN - 1);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ITER,
		C_FINISH
	} cordic_state_t;

	cordic_state_t               state_q;
	logic [STEP_W-1:0]           step_q;
	logic signed [CORDIC_XW-1:0] x_q;
	logic signed [CORDIC_XW-1:0] y_q;
	logic signed [CORDIC_ZW-1:0] z_q;
	logic                        flip_q;
	logic signed [TRIG_W-1:0]    cos_q;
	logic signed [TRIG_W-1:0]    sin_q;

	logic signed [CORDIC_ZW-1:0] z_raw;
	logic signed [CORDIC_ZW-1:0] z_init;
	logic                        flip_init;
	logic signed [CORDIC_XW-1:0] xs;
	logic signed [CORDIC_XW-1:0] ys;
	logic signed [CORDIC_ZW-1:0] atan_v;
	logic signed [TRIG_W-1:0]    cos_r;
	logic signed [TRIG_W-1:0]    sin_r;

	// Round a Q2.30 value to Q1.16 (half up) and clamp it to one.
	function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [CORDIC_XW-1:0] v);
		logic signed [CORDIC_XW-1:0] r;
		logic signed [TRIG_W-1:0]    o;
		r = (v + CORDIC_XW'(8192)) >>> 14;
		if (r > CORDIC_XW'(UNIT_Q16)) begin
			o = UNIT_Q16;
		end else if (r < -CORDIC_XW'(UNIT_Q16)) begin
			o = -UNIT_Q16;
		end else begin
			o = r[TRIG_W-1:0];
		end
		return o;
	endfunction

	// Scale the Q3.13 angle to Q2.30 and fold it into the right half-plane.
	always_comb begin
		z_raw = CORDIC_ZW'($signed(angle)) <<< 17;
		if (z_raw > Q30_HALF_PI) begin
			z_init    = z_raw - Q30_PI;
			flip_init = 1'b1;
		end else if (z_raw < -Q30_HALF_PI) begin
			z_init    = z_raw + Q30_PI;
			flip_init = 1'b1;
		end else begin
			z_init    = z_raw;
			flip_init = 1'b0;
		end
	end

	// One rotation step: shifted copies and the step's arctangent.
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_v = CORDIC_ZW'(atan_q30(ATAN_IDX_W'(step_q)));

	// Final rounding, with the half-turn sign restored.
	always_comb begin
		cos_r = to_q16(x_q);
		sin_r = to_q16(y_q);
		if (flip_q) begin
			cos_r = -cos_r;
			sin_r = -sin_r;
		end
	end

	// Sequencer, working registers and the kept cosine and sine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			flip_q  <= 1'b0;
			cos_q   <= UNIT_Q16;
			sin_q   <= '0;
		end else if (start) begin
			// A new angle restarts the rotation from any state.
			state_q <= C_ITER;
			step_q  <= '0;
			x_q     <= Q30_GAIN_INV;
			y_q     <= '0;
			z_q     <= z_init;
			flip_q  <= flip_init;
		end else begin
			case (state_q)
				C_IDLE: begin
					state_q <= C_IDLE;
				end
				C_ITER: begin
					if (!z_q[CORDIC_ZW-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_v;
					end
					if (step_q == STEP_LAST) begin
						state_q <= C_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				C_FINISH: begin
					cos_q   <= cos_r;
					sin_q   <= sin_r;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign trig.busy  = (state_q != C_IDLE);
	assign trig.cos_v = cos_q;
	assign trig.sin_v = sin_q;

	// The kept cosine never leaves the unit circle range.
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cos_q <= UNIT_Q16) && (cos_q >= -UNIT_Q16))
		else $error("cosine out of range");

	// Only the final step updates the kept values.
	a_trig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != C_FINISH) |=> ($stable(cos_q) && $stable(sin_q)))
		else $error("cosine or sine changed outside the final step");

	// A start from idle begins at the first step.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == C_IDLE) |=> (state_q == C_ITER && step_q == '0))
		else $error("rotation did not start at step zero");

endmodule

`default_nettype wire

FILE: sv/planar_rigid_transform.sv
// ----------------------------------------------------------------------------
// planar_rigid_transform: fixed SE(2) transform of points and twists
// Five-stage multiply, sum, round and saturate pipeline around a kept
// cosine and sine that an iterative rotation unit computes per angle write.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with mode, in_x, in_y, in_w. A beat
//   moves when in_valid is high and in_stall is low. mode 0 rotates the
//   point and then adds the translation; mode 1 maps a twist through the
//   adjoint and passes in_w through. All values are Q16.16.
//   Output channel: out_valid / out_stall with out_x, out_y, out_w, one beat
//   per input beat, in order, saturated to the signed 32-bit range.
//   Configuration: wr_en, wr_index, wr_data; index 0 angle (Q3.13), 1 and 2
//   the translation. Unknown indexes are ignored.
// Throughput
//   One beat per cycle is sustained while out_stall is low and no angle
//   write or rotation is under way. The rate is set by the five register
//   stages, each holding one multiplier layer or one wide add and compare.
//   An angle write starts the rotation unit, one step per cycle: in_stall is
//   high from the write cycle until the new cosine and sine are kept.
// Reset and stalls
//   Reset empties the pipeline, sets cosine to one, sine and translation to
//   zero. A stalled output holds its beat; empty stages still fill, and the
//   input stalls when every stage holds a beat or an angle update is under way.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_rigid_transform
	import prt_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        wr_en,
	input  wire logic [REG_IDX_W-1:0]        wr_index,
	input  wire logic [CFG_DATA_W-1:0]       wr_data,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        mode,
	input  wire logic signed [COORD_W-1:0]   in_x,
	input  wire logic signed [COORD_W-1:0]   in_y,
	input  wire logic signed [COORD_W-1:0]   in_w,
	// output channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [COORD_W-1:0]        out_x,
	output logic signed [COORD_W-1:0]        out_y,
	output logic signed [COORD_W-1:0]        out_w
);

	localparam int unsigned PS_W  = TRIG_W + COORD_W;   // rotation product
	localparam int unsigned PW_W  = 2 * COORD_W;        // rate times shift
	localparam int unsigned SA_W  = PS_W + 1;           // rotation sum
	localparam int unsigned SUM_W = PW_W + 2;           // full sum
	localparam int unsigned RND_W = SUM_W - 16;         // after rounding shift

	// Configuration and rotation unit.
	logic signed [COORD_W-1:0] shift_x_q;
	logic signed [COORD_W-1:0] shift_y_q;
	logic                      angle_wr;
	prt_trig_t                 trig;

	// Stage enables and valid bits.
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic in_acc;

	// Stage 1: products.
	logic                      mode_s1;
	logic signed [COORD_W-1:0] w_s1;
	logic signed [PS_W-1:0]    cx_s1, sy_s1, sx_s1, cy_s1;
	logic signed [PW_W-1:0]    wty_s1, wtx_s1;
	logic signed [PS_W-1:0]    m_cx, m_sy, m_sx, m_cy;
	logic signed [PW_W-1:0]    m_wty, m_wtx;
	// Stage 2: rotation sums.
	logic                      mode_s2;
	logic signed [COORD_W-1:0] w_s2;
	logic signed [SA_W-1:0]    ax_s2, ay_s2;
	logic signed [PW_W-1:0]    wy_s2, wx_s2;
	// Stage 3: full sums rounded.
	logic                      mode_s3;
	logic signed [COORD_W-1:0] w_s3;
	logic signed [RND_W-1:0]   rx_s3, ry_s3;
	logic signed [SUM_W-1:0]   vx, vy;
	// Stage 4: saturated rotation.
	logic                      mode_s4;
	logic signed [COORD_W-1:0] w_s4;
	logic signed [COORD_W-1:0] sx_s4, sy_s4;
	// Stage 5: output register.
	logic                      mode_s5;
	logic signed [COORD_W-1:0] x_s5, y_s5, w_s5;

	// Saturate the rounded sum to 32 bits.
	function automatic logic signed [COORD_W-1:0] sat_rnd(input logic signed [RND_W-1:0] v);
		logic signed [COORD_W-1:0] o;
		// The value fits when bit 31 and every bit above it match the sign bit.
		if (!v[RND_W-1] && (|v[RND_W-2:COORD_W-1])) begin
			o = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v[RND_W-1] && !(&v[RND_W-2:COORD_W-1])) begin
			o = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			o = v[COORD_W-1:0];
		end
		return o;
	endfunction

	// Add a translation component and saturate.
	function automatic logic signed [COORD_W-1:0] add_sat(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0]   s;
		logic signed [COORD_W-1:0] o;
		s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
		if (s[COORD_W] != s[COORD_W-1]) begin
			o = {s[COORD_W], {(COORD_W-1){~s[COORD_W]}}};
		end else begin
			o = s[COORD_W-1:0];
		end
		return o;
	endfunction

	// Translation registers; the angle goes straight to the rotation unit.
	assign angle_wr = wr_en && (wr_index == REG_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q <= '0;
			shift_y_q <= '0;
		end else if (wr_en) begin
			if (wr_index == REG_SHIFT_X) begin
				shift_x_q <= wr_data[COORD_W-1:0];
			end
			if (wr_index == REG_SHIFT_Y) begin
				shift_y_q <= wr_data[COORD_W-1:0];
			end
		end
	end

	prt_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (angle_wr),
		.angle  (wr_data[ANGLE_W-1:0]),
		.trig   (trig)
	);

	// A stage moves when it is empty or the next stage moves.
	assign en_s5    = !v_s5 || !out_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1 || trig.busy || angle_wr;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_acc;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: rotation products; rate products only for twists.
	assign m_cx  = trig.cos_v * in_x;
	assign m_sy  = trig.sin_v * in_y;
	assign m_sx  = trig.sin_v * in_x;
	assign m_cy  = trig.cos_v * in_y;
	assign m_wty = mode ? in_w * shift_y_q : $signed({PW_W{1'b0}});
	assign m_wtx = mode ? in_w * shift_x_q : $signed({PW_W{1'b0}});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1 <= mode;
			w_s1    <= in_w;
			cx_s1   <= m_cx;
			sy_s1   <= m_sy;
			sx_s1   <= m_sx;
			cy_s1   <= m_cy;
			wty_s1  <= m_wty;
			wtx_s1  <= m_wtx;
		end
	end

	// Stage 2: rotated vector with 32 fraction bits.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2 <= mode_s1;
			w_s2    <= w_s1;
			ax_s2   <= SA_W'(cx_s1) - SA_W'(sy_s1);
			ay_s2   <= SA_W'(sx_s1) + SA_W'(cy_s1);
			wy_s2   <= wty_s1;
			wx_s2   <= -wtx_s1;
		end
	end

	// Stage 3: add the rate terms and round half up to Q16.16.
	assign vx = SUM_W'(wy_s2) + SUM_W'(ax_s2) + SUM_W'(32768);
	assign vy = SUM_W'(wx_s2) + SUM_W'(ay_s2) + SUM_W'(32768);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mode_s3 <= mode_s2;
			w_s3    <= w_s2;
			rx_s3   <= vx[SUM_W-1:16];
			ry_s3   <= vy[SUM_W-1:16];
		end
	end

	// Stage 4: saturate to 32 bits.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			mode_s4 <= mode_s3;
			w_s4    <= w_s3;
			sx_s4   <= sat_rnd(rx_s3);
			sy_s4   <= sat_rnd(ry_s3);
		end
	end

	// Stage 5: points take the translation; twists pass the rate through.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			mode_s5 <= mode_s4;
			x_s5    <= mode_s4 ? sx_s4 : add_sat(sx_s4, shift_x_q);
			y_s5    <= mode_s4 ? sy_s4 : add_sat(sy_s4, shift_y_q);
			w_s5    <= mode_s4 ? w_s4 : '0;
		end
	end

	assign out_valid = v_s5;
	assign out_x     = x_s5;
	assign out_y     = y_s5;
	assign out_w     = w_s5;

	// No item enters while the rotation unit is updating the trig values.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !trig.busy)
		else $error("item accepted while the rotation unit is busy");

	// A point result always carries a zero rate.
	a_point_w: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mode_s5) |-> (out_w == '0))
		else $error("point result with non-zero rate");

	// A beat in the last stage that is not taken stays there.
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && out_stall) |=> (v_s5 && $stable(x_s5) && $stable(y_s5)))
		else $error("stalled result lost or changed");

	// A full pipeline with a stalled output takes nothing in.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall) |-> !in_acc)
		else $error("item accepted into a full pipeline");

endmodule

`default_nettype wire
